[src/rybrgb_pkg.sv]
package rybrgb_pkg;

	localparam int CH_W            = 12;
	localparam int CORNER_W        = 3 * CH_W;
	localparam int NUM_CORNERS     = 8;
	localparam int IDX_W           = $clog2(NUM_CORNERS);
	localparam int PIX_W           = 8;
	localparam int W_BITS          = 14;
	localparam int WGT_W           = W_BITS + 1;
	localparam int FRAC_BITS_DEFAULT = 11;
	localparam logic [WGT_W-1:0] W_ONE = WGT_W'(1 << W_BITS);
	localparam longint unsigned CUBE_DEN = 64'd16581375;

	typedef struct packed {
		logic [PIX_W-1:0] red_in;
		logic [PIX_W-1:0] yellow_in;
		logic [PIX_W-1:0] blue_in;
	} pixel_in_t;

	typedef struct packed {
		logic [PIX_W-1:0] red_out;
		logic [PIX_W-1:0] green_out;
		logic [PIX_W-1:0] blue_out;
	} pixel_out_t;

	typedef logic [NUM_CORNERS-1:0][CORNER_W-1:0] corner_set_t;
	typedef logic [(1 << PIX_W)-1:0][WGT_W-1:0]   w_table_t;

	localparam corner_set_t CORNER_RESET = {
		36'd0,              // black
		36'd17179870208,    // purple
		36'd5538202,        // green
		36'd270768120,      // blue
		36'd34363932672,    // orange
		36'd34359738368,    // red
		36'd34368126976,    // yellow
		36'd34368129024     // white
	};

	// smoothstep weight, 14 fraction bits, rounded to nearest
	function automatic w_table_t build_w_table();
		w_table_t t;
		longint unsigned num;
		for (int v = 0; v < (1 << PIX_W); v++) begin
			num = 64'(v) * 64'(v) * 64'(765 - 2 * v);
			t[v] = WGT_W'((num * 64'(W_ONE) + CUBE_DEN / 2) / CUBE_DEN);
		end
		return t;
	endfunction

	localparam w_table_t W_TABLE = build_w_table();

endpackage

[src/rybrgb_cfg.sv]
module rybrgb_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [rybrgb_pkg::IDX_W-1:0]       cfg_index,
	input  logic [rybrgb_pkg::CORNER_W-1:0]    cfg_data,
	output rybrgb_pkg::corner_set_t            corners
);
	import rybrgb_pkg::*;

	corner_set_t corner_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_q <= CORNER_RESET;
		end else if (cfg_write) begin
			corner_q[cfg_index] <= cfg_data;
		end
	end

	assign corners = corner_q;

endmodule

[src/rybrgb_mix.sv]
module rybrgb_mix #(
	parameter int IN_W = 12
) (
	input  logic [IN_W-1:0]                a,
	input  logic [IN_W-1:0]                c,
	input  logic [rybrgb_pkg::WGT_W-1:0]   w,
	output logic [IN_W+rybrgb_pkg::W_BITS-1:0] y
);
	import rybrgb_pkg::*;

	logic [WGT_W-1:0]      w_inv;
	logic [IN_W+WGT_W-1:0] prod_a;
	logic [IN_W+WGT_W-1:0] prod_c;
	logic [IN_W+WGT_W-1:0] sum;

	assign w_inv  = W_ONE - w;
	assign prod_a = (IN_W+WGT_W)'(a) * (IN_W+WGT_W)'(w_inv);
	assign prod_c = (IN_W+WGT_W)'(c) * (IN_W+WGT_W)'(w);
	assign sum    = prod_a + prod_c;
	assign y      = sum[IN_W+W_BITS-1:0];

endmodule

[src/ryb_to_rgb_cube_interpolator.sv]
// channel  | direction | handshake                   | payload
// paint    | in        | paint_valid / paint_stall   | pixel_in_t  (red, yellow, blue)
// light    | out       | light_valid / light_stall   | pixel_out_t (red, green, blue)
// cfg      | in        | cfg_write                   | cfg_index, cfg_data (corner 0..7)
//
// One pixel per clock while light is not stalled; each pixel passes every stage in turn before light valid.
// Stages: weight lookup, blue blends, yellow blends, red blend, scale and saturate.
// Reset loads the eight default corners and empties every stage.
// A stall at light halts only full stages; bubbles still close up behind it.
// paint_stall rises only when all five stages hold an item.
module ryb_to_rgb_cube_interpolator #(
	parameter int FRAC_BITS = rybrgb_pkg::FRAC_BITS_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             paint_valid,
	output logic                             paint_stall,
	input  rybrgb_pkg::pixel_in_t            paint,
	output logic                             light_valid,
	input  logic                             light_stall,
	output rybrgb_pkg::pixel_out_t           light,
	input  logic                             cfg_write,
	input  logic [rybrgb_pkg::IDX_W-1:0]     cfg_index,
	input  logic [rybrgb_pkg::CORNER_W-1:0]  cfg_data
);
	import rybrgb_pkg::*;

	localparam int B_W   = CH_W + W_BITS;
	localparam int Y_W   = B_W + W_BITS;
	localparam int R_W   = Y_W + W_BITS;
	localparam int SC_W  = R_W + PIX_W;
	localparam int SHIFT = FRAC_BITS + 3 * W_BITS;

	corner_set_t corners;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic ready_s1, ready_s2, ready_s3, ready_s4, ready_s5;

	logic [WGT_W-1:0] wr_s1, wy_s1, wb_s1;
	logic [WGT_W-1:0] wr_s2, wy_s2;
	logic [WGT_W-1:0] wr_s3;

	logic [2:0][3:0][B_W-1:0] bmix_d, bmix_s2;
	logic [2:0][1:0][Y_W-1:0] ymix_d, ymix_s3;
	logic [2:0][R_W-1:0]      rmix_d, rmix_s4;
	logic [2:0][PIX_W-1:0]    chan_d;
	pixel_out_t               light_q;
	logic                     light_valid_q;

	rybrgb_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.corners   (corners)
	);

	assign ready_s5    = !light_valid_q || !light_stall;
	assign ready_s4    = !valid_s4 || ready_s5;
	assign ready_s3    = !valid_s3 || ready_s4;
	assign ready_s2    = !valid_s2 || ready_s3;
	assign ready_s1    = !valid_s1 || ready_s2;
	assign paint_stall = !ready_s1;

	for (genvar ch = 0; ch < 3; ch++) begin : g_chan
		localparam int LSB = (2 - ch) * CH_W;
		logic [SC_W-1:0] scaled;
		logic [SC_W-1:0] shifted;

		for (genvar k = 0; k < 4; k++) begin : g_blue
			rybrgb_mix #(.IN_W(CH_W)) u_mix (
				.a (corners[k][LSB +: CH_W]),
				.c (corners[k+4][LSB +: CH_W]),
				.w (wb_s1),
				.y (bmix_d[ch][k])
			);
		end

		for (genvar k = 0; k < 2; k++) begin : g_yellow
			rybrgb_mix #(.IN_W(B_W)) u_mix (
				.a (bmix_s2[ch][2*k]),
				.c (bmix_s2[ch][2*k+1]),
				.w (wy_s2),
				.y (ymix_d[ch][k])
			);
		end

		rybrgb_mix #(.IN_W(Y_W)) u_red (
			.a (ymix_s3[ch][0]),
			.c (ymix_s3[ch][1]),
			.w (wr_s3),
			.y (rmix_d[ch])
		);

		// times 255 as shift and subtract
		assign scaled  = (SC_W'(rmix_s4[ch]) << PIX_W) - SC_W'(rmix_s4[ch]);
		assign shifted = scaled >> SHIFT;
		assign chan_d[ch] = (|shifted[SC_W-1:PIX_W]) ? {PIX_W{1'b1}} : shifted[PIX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
			valid_s3      <= 1'b0;
			valid_s4      <= 1'b0;
			light_valid_q <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= paint_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
			if (ready_s4) valid_s4 <= valid_s3;
			if (ready_s5) light_valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && paint_valid) begin
			wr_s1 <= W_TABLE[paint.red_in];
			wy_s1 <= W_TABLE[paint.yellow_in];
			wb_s1 <= W_TABLE[paint.blue_in];
		end
		if (ready_s2 && valid_s1) begin
			bmix_s2 <= bmix_d;
			wr_s2   <= wr_s1;
			wy_s2   <= wy_s1;
		end
		if (ready_s3 && valid_s2) begin
			ymix_s3 <= ymix_d;
			wr_s3   <= wr_s2;
		end
		if (ready_s4 && valid_s3) begin
			rmix_s4 <= rmix_d;
		end
		if (ready_s5 && valid_s4) begin
			light_q.red_out   <= chan_d[0];
			light_q.green_out <= chan_d[1];
			light_q.blue_out  <= chan_d[2];
		end
	end

	assign light       = light_q;
	assign light_valid = light_valid_q;

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		paint_stall |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4 && light_valid_q))
		else $error("paint stalled with a free stage");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		paint_valid && !paint_stall |=> valid_s1)
		else $error("transfer lost at stage one");

	a_hold_s2: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !ready_s3 |=> valid_s2 && $stable(wy_s2) && $stable(wr_s2))
		else $error("stage two changed while held");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && !light_stall |=> light_valid_q)
		else $error("stage four item not delivered");

endmodule
